FILE: hw/rtl/rsh_pkg.sv
// ---------------------------------------------------------------------------
// rsh_pkg
// Shared types and constants for the timed window RSSI histogram unit.
// ---------------------------------------------------------------------------
package rsh_pkg;

   localparam int BINS     = 120;
   localparam int BIN_AW   = $clog2(BINS);
   localparam int PTR_W    = BIN_AW + 1;
   localparam int BIN_W    = 16;
   localparam int CNT_W    = 24;
   localparam int CUM_W    = $clog2(BINS * 65536);
   localparam int TGT_W    = 31;
   localparam int REG_W    = 31;
   localparam int ADDR_W   = 4;

   // mean divider: |sum*10| fits 35 bits, quotient magnitude at most 1200
   localparam int DIV_NW   = 35;
   localparam int DIV_QW   = 11;
   localparam int DIV_CW   = $clog2(DIV_QW);

   localparam logic [BIN_W-1:0] BIN_MAX   = 16'hFFFF;
   localparam logic [CNT_W-1:0] COUNT_MAX = 24'hFFFFFF;
   localparam logic signed [7:0] LOW_DBM  = -8'sd120;

   typedef enum logic [1:0] {
      REQ_START  = 2'd0,
      REQ_STOP   = 2'd1,
      REQ_SAMPLE = 2'd2,
      REQ_QUERY  = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_TOO_SHORT = 2'd1,
      ST_TOO_LONG  = 2'd2,
      ST_NO_DATA   = 2'd3
   } status_type;

   localparam logic [1:0] REG_DEFAULT = 2'd0;
   localparam logic [1:0] REG_MIN     = 2'd1;
   localparam logic [1:0] REG_MAX     = 2'd2;

endpackage

FILE: hw/rtl/timed_window_rssi_histogram_stats_unit.sv
// ---------------------------------------------------------------------------
// timed_window_rssi_histogram_stats_unit
// Measurement window with deadline, RSSI histogram and percentile statistics.
// ---------------------------------------------------------------------------
// Each request passes the apply step, then the update step for a sample that
// enters the store, then the stats step. When the store is empty after the
// request, the stats step gives the result strobe. Otherwise the statistics
// walk reads the histogram RAM one bin a cycle through its single read port,
// and the mean then goes through the bit-serial divider (a load, then 11
// quotient bits). busy is high for the whole request. The result is held on
// the rsp_ ports and marked by rsp_valid for one cycle only; the receiver cannot
// stall it, so it must take every beat as it comes.
module timed_window_rssi_histogram_stats_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_type,
   input  logic [31:0]                   req_now_ms,
   input  logic [31:0]                   req_duration_ms,
   input  logic signed [7:0]             req_rssi_dbm,
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_status,
   output logic                          rsp_window_active,
   output logic                          rsp_expired_event,
   output logic [rsh_pkg::REG_W-1:0]     rsp_remaining_ms,
   output logic [rsh_pkg::CNT_W-1:0]     rsp_sample_count,
   output logic signed [7:0]             rsp_min_dbm,
   output logic signed [7:0]             rsp_max_dbm,
   output logic signed [7:0]             rsp_p5_dbm,
   output logic signed [7:0]             rsp_median_dbm,
   output logic signed [7:0]             rsp_p95_dbm,
   output logic signed [11:0]            rsp_mean_x10,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [rsh_pkg::ADDR_W-1:0]    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import rsh_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_APPLY, S_UPDATE, S_STATS, S_WALK, S_DIV
   } state_type;

   state_type state_ff;

   // configuration
   logic [REG_W-1:0] reg_default_ff, reg_min_ff, reg_max_ff;

   // latched request
   req_kind_type     kind_ff;
   logic [31:0]      now_ff, dur_ff;
   logic signed [7:0] rssi_ff;

   // window and store
   logic [31:0]       deadline_ff;
   logic              running_ff, pending_ff;
   logic [BINS-1:0]   valid_ff;
   logic [CNT_W-1:0]  total_ff;
   logic signed [31:0] sum_ff;
   logic signed [7:0] lowest_ff, highest_ff;
   logic [BIN_AW-1:0] idx_ff;

   // per request results
   logic [1:0]        status_ff;
   logic              active_ff, expired_ff;
   logic [REG_W-1:0]  remaining_ff;

   // walk
   logic [PTR_W-1:0]  ptr_ff;
   logic              proc_ff;
   logic [BIN_AW-1:0] pidx_ff;
   logic [CUM_W-1:0]  cum_ff;
   logic [TGT_W-1:0]  t5_ff, t50_ff, t95_ff;
   logic              f5_ff, f50_ff, f95_ff;
   logic signed [7:0] p5_ff, p50_ff, p95_ff;
   logic              neg_ff;
   logic [DIV_NW-1:0] mag_ff;

   // outputs
   logic              rsp_valid_ff;
   logic [1:0]        rsp_status_ff;
   logic              rsp_active_ff, rsp_expired_ff;
   logic [REG_W-1:0]  rsp_remaining_ff;
   logic [CNT_W-1:0]  rsp_count_ff;
   logic signed [7:0] rsp_min_ff, rsp_max_ff, rsp_p5_ff, rsp_p50_ff, rsp_p95_ff;
   logic signed [11:0] rsp_mean_ff;

   // ---- apply step ----
   logic [31:0]      diff_in, dur_eff_in, dl_in, left_in;
   logic             expire_in, run_now_in, run_in, pend_in, expired_in, take_in;
   logic [1:0]       status_in;
   logic             arm_in;

   always_comb begin
      diff_in    = now_ff - deadline_ff;
      expire_in  = running_ff && !diff_in[31];
      run_now_in = running_ff && !expire_in;
      dur_eff_in = (dur_ff == '0) ? {1'b0, reg_default_ff} : dur_ff;
      status_in  = ST_OK;
      arm_in     = 1'b0;
      run_in     = run_now_in;
      pend_in    = pending_ff || expire_in;
      dl_in      = deadline_ff;
      expired_in = 1'b0;
      take_in    = 1'b0;
      unique case (kind_ff)
         REQ_START: begin
            if (dur_eff_in < {1'b0, reg_min_ff}) begin
               status_in = ST_TOO_SHORT;
            end else if (dur_eff_in > {1'b0, reg_max_ff}) begin
               status_in = ST_TOO_LONG;
            end else begin
               arm_in  = 1'b1;
               run_in  = 1'b1;
               pend_in = 1'b0;
               dl_in   = now_ff + dur_eff_in;
            end
         end
         REQ_STOP: begin
            run_in  = 1'b0;
            pend_in = 1'b0;
            dl_in   = '0;
         end
         REQ_SAMPLE: begin
            take_in = run_now_in && rssi_ff[7] && (rssi_ff >= LOW_DBM);
         end
         REQ_QUERY: begin
            expired_in = pend_in;
            pend_in    = 1'b0;
            if (total_ff == '0) begin
               status_in = ST_NO_DATA;
            end
         end
         default: ;
      endcase
      left_in = dl_in - now_ff;
   end

   logic [7:0]        sidx_in;
   assign sidx_in = 8'(rssi_ff) + 8'd120;

   // ---- histogram RAM ----
   logic              ram_we;
   logic [BIN_AW-1:0] ram_raddr;
   logic [BIN_W-1:0]  ram_rdata, bin_in, bin_inc_in;

   assign ram_raddr  = (state_ff == S_APPLY) ? sidx_in[BIN_AW-1:0] : ptr_ff[BIN_AW-1:0];
   assign ram_we     = (state_ff == S_UPDATE);
   assign bin_in     = valid_ff[idx_ff] ? ram_rdata : '0;
   assign bin_inc_in = (bin_in == BIN_MAX) ? bin_in : bin_in + 1'b1;

   rsh_ram #(.WIDTH(BIN_W), .DEPTH(BINS)) u_bins (
      .clock (clock),
      .we    (ram_we),
      .waddr (idx_ff),
      .wdata (bin_inc_in),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // ---- walk step: compare 100*cum against pct*count, same as the ceil rank ----
   logic [BIN_W-1:0] wbin_in;
   logic [CUM_W-1:0] cum_in;
   logic [TGT_W-1:0] cum100_in;
   logic             hit5_in, hit50_in, hit95_in;
   logic signed [7:0] val_in;

   always_comb begin
      wbin_in   = valid_ff[pidx_ff] ? ram_rdata : '0;
      cum_in    = cum_ff + CUM_W'(wbin_in);
      cum100_in = (TGT_W'(cum_in) << 6) + (TGT_W'(cum_in) << 5) + (TGT_W'(cum_in) << 2);
      hit5_in   = cum100_in >= t5_ff;
      hit50_in  = cum100_in >= t50_ff;
      hit95_in  = cum100_in >= t95_ff;
      val_in    = 8'({1'b0, pidx_ff}) + LOW_DBM;
   end

   logic [31:0] abs_sum_in;
   assign abs_sum_in = sum_ff[31] ? 32'(-sum_ff) : 32'(sum_ff);

   // ---- mean divider ----
   logic              div_start, div_done;
   logic [DIV_QW-1:0] div_q;

   assign div_start = (state_ff == S_WALK) && proc_ff && (pidx_ff == BIN_AW'(BINS - 1));

   rsh_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mag_ff),
      .divisor  (total_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   logic [11:0] q_ext_in;
   assign q_ext_in = 12'(div_q);

   // ---- sequencer ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         reg_default_ff <= REG_W'(600000);
         reg_min_ff     <= REG_W'(60000);
         reg_max_ff     <= REG_W'(3600000);
         deadline_ff    <= '0;
         running_ff     <= 1'b0;
         pending_ff     <= 1'b0;
         valid_ff       <= '0;
         total_ff       <= '0;
         sum_ff         <= '0;
         lowest_ff      <= '0;
         highest_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
         proc_ff        <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;

         if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
               REG_DEFAULT: reg_default_ff <= pwdata[REG_W-1:0];
               REG_MIN:     reg_min_ff     <= pwdata[REG_W-1:0];
               REG_MAX:     reg_max_ff     <= pwdata[REG_W-1:0];
               default: ;
            endcase
         end

         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  kind_ff  <= req_kind_type'(req_type);
                  now_ff   <= req_now_ms;
                  dur_ff   <= req_duration_ms;
                  rssi_ff  <= req_rssi_dbm;
                  state_ff <= S_APPLY;
               end
            end
            S_APPLY: begin
               running_ff   <= run_in;
               pending_ff   <= pend_in;
               deadline_ff  <= dl_in;
               status_ff    <= status_in;
               active_ff    <= run_in;
               expired_ff   <= expired_in;
               remaining_ff <= (run_in && left_in != '0 && !left_in[31])
                               ? left_in[REG_W-1:0] : '0;
               idx_ff       <= sidx_in[BIN_AW-1:0];
               if (arm_in) begin
                  valid_ff   <= '0;
                  total_ff   <= '0;
                  sum_ff     <= '0;
                  lowest_ff  <= '0;
                  highest_ff <= '0;
               end
               state_ff <= take_in ? S_UPDATE : S_STATS;
            end
            S_UPDATE: begin
               valid_ff[idx_ff] <= 1'b1;
               if (total_ff == '0) begin
                  lowest_ff  <= rssi_ff;
                  highest_ff <= rssi_ff;
               end else begin
                  if (rssi_ff < lowest_ff)  lowest_ff  <= rssi_ff;
                  if (rssi_ff > highest_ff) highest_ff <= rssi_ff;
               end
               if (total_ff != COUNT_MAX) begin
                  total_ff <= total_ff + 1'b1;
                  sum_ff   <= sum_ff + 32'(rssi_ff);
               end
               state_ff <= S_STATS;
            end
            S_STATS: begin
               if (total_ff == '0) begin
                  rsp_valid_ff     <= 1'b1;
                  rsp_status_ff    <= status_ff;
                  rsp_active_ff    <= active_ff;
                  rsp_expired_ff   <= expired_ff;
                  rsp_remaining_ff <= remaining_ff;
                  rsp_count_ff     <= '0;
                  rsp_min_ff       <= '0;
                  rsp_max_ff       <= '0;
                  rsp_p5_ff        <= '0;
                  rsp_p50_ff       <= '0;
                  rsp_p95_ff       <= '0;
                  rsp_mean_ff      <= '0;
                  state_ff         <= S_IDLE;
               end else begin
                  t5_ff    <= TGT_W'(total_ff) * TGT_W'(5);
                  t50_ff   <= TGT_W'(total_ff) * TGT_W'(50);
                  t95_ff   <= TGT_W'(total_ff) * TGT_W'(95);
                  neg_ff   <= sum_ff[31];
                  mag_ff   <= (DIV_NW'(abs_sum_in) << 3) + (DIV_NW'(abs_sum_in) << 1);
                  // bins may saturate, so an unreached rank falls back to the maximum
                  p5_ff    <= highest_ff;
                  p50_ff   <= highest_ff;
                  p95_ff   <= highest_ff;
                  f5_ff    <= 1'b0;
                  f50_ff   <= 1'b0;
                  f95_ff   <= 1'b0;
                  cum_ff   <= '0;
                  ptr_ff   <= '0;
                  proc_ff  <= 1'b0;
                  state_ff <= S_WALK;
               end
            end
            S_WALK: begin
               if (ptr_ff < PTR_W'(BINS)) begin
                  ptr_ff <= ptr_ff + 1'b1;
               end
               // drops on its own once the pointer has passed the last bin
               proc_ff <= ptr_ff < PTR_W'(BINS);
               pidx_ff <= ptr_ff[BIN_AW-1:0];
               if (proc_ff) begin
                  cum_ff <= cum_in;
                  if (!f5_ff && hit5_in) begin
                     f5_ff <= 1'b1;
                     p5_ff <= val_in;
                  end
                  if (!f50_ff && hit50_in) begin
                     f50_ff <= 1'b1;
                     p50_ff <= val_in;
                  end
                  if (!f95_ff && hit95_in) begin
                     f95_ff <= 1'b1;
                     p95_ff <= val_in;
                  end
                  if (div_start) begin
                     state_ff <= S_DIV;
                  end
               end
            end
            S_DIV: begin
               if (div_done) begin
                  rsp_valid_ff     <= 1'b1;
                  rsp_status_ff    <= status_ff;
                  rsp_active_ff    <= active_ff;
                  rsp_expired_ff   <= expired_ff;
                  rsp_remaining_ff <= remaining_ff;
                  rsp_count_ff     <= total_ff;
                  rsp_min_ff       <= lowest_ff;
                  rsp_max_ff       <= highest_ff;
                  rsp_p5_ff        <= p5_ff;
                  rsp_p50_ff       <= p50_ff;
                  rsp_p95_ff       <= p95_ff;
                  rsp_mean_ff      <= neg_ff ? 12'(-q_ext_in) : q_ext_in;
                  state_ff         <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_DEFAULT: prdata = {1'b0, reg_default_ff};
         REG_MIN:     prdata = {1'b0, reg_min_ff};
         REG_MAX:     prdata = {1'b0, reg_max_ff};
         default:     prdata = '0;
      endcase
   end

   assign pready            = 1'b1;
   assign busy              = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_window_active = rsp_active_ff;
   assign rsp_expired_event = rsp_expired_ff;
   assign rsp_remaining_ms  = rsp_remaining_ff;
   assign rsp_sample_count  = rsp_count_ff;
   assign rsp_min_dbm       = rsp_min_ff;
   assign rsp_max_dbm       = rsp_max_ff;
   assign rsp_p5_dbm        = rsp_p5_ff;
   assign rsp_median_dbm    = rsp_p50_ff;
   assign rsp_p95_dbm       = rsp_p95_ff;
   assign rsp_mean_x10      = rsp_mean_ff;

`ifndef ASSERT_OFF
   // every request ends in exactly one result beat
   a_done_beat: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_valid)
      else $error("request finished without a result beat");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   // a higher rank is never found before a lower one
   a_walk_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (f50_ff || !f95_ff) && (f5_ff || !f50_ff))
      else $error("percentile ranks found out of order");
`endif

endmodule

FILE: hw/rtl/rsh_ram.sv
// ---------------------------------------------------------------------------
// rsh_ram
// Generic single write, single read port RAM with registered read data.
// ---------------------------------------------------------------------------
module rsh_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 120
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: hw/rtl/rsh_div.sv
// ---------------------------------------------------------------------------
// rsh_div
// Restoring divider for the mean: one quotient bit per cycle.
// ---------------------------------------------------------------------------
module rsh_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [rsh_pkg::DIV_NW-1:0]  dividend,
   input  logic [rsh_pkg::CNT_W-1:0]   divisor,
   output logic                        done,
   output logic [rsh_pkg::DIV_QW-1:0]  quotient
);
   import rsh_pkg::*;

   logic [DIV_NW-1:0] rem_ff;
   logic [DIV_NW-1:0] dsh_ff;
   logic [DIV_QW-1:0] q_ff;
   logic [DIV_CW-1:0] cnt_ff;
   logic              run_ff;
   logic              done_ff;
   logic              fits_in;

   assign fits_in = rem_ff >= dsh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff <= dividend;
            dsh_ff <= DIV_NW'({divisor, {(DIV_QW-1){1'b0}}});
            q_ff   <= '0;
            cnt_ff <= DIV_CW'(DIV_QW - 1);
            run_ff <= 1'b1;
         end else if (run_ff) begin
            if (fits_in) begin
               rem_ff <= rem_ff - dsh_ff;
            end
            q_ff   <= {q_ff[DIV_QW-2:0], fits_in};
            dsh_ff <= dsh_ff >> 1;
            if (cnt_ff == '0) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule
